// File: src/tvrg_pkg.sv
`default_nettype none

package tvrg_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_FINISH
  } state_t;

  // lanes: one per vector, each with up to three components
  localparam int LANES      = 3;
  localparam int COMPS      = 3;
  localparam int LANE_ACCEL = 0;
  localparam int LANE_GYRO  = 1;
  localparam int LANE_TILT  = 2;

  localparam int OPND_W = 16;
  localparam int SUM_W  = 2 * OPND_W;
  localparam int REM_W  = OPND_W + 2;
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(OPND_W - 1);

  typedef logic [OPND_W-1:0] opnd_t;
  typedef logic [SUM_W-1:0]  sum_t;

  // tilt tiers on squared sums
  localparam sum_t TILT_T1 = 32'd250000;
  localparam sum_t TILT_T2 = 32'd1000000;
  localparam sum_t TILT_T3 = 32'd2250000;
  localparam sum_t TILT_T4 = 32'd4000000;
  // vibration tiers on squared sums
  localparam sum_t VIB_T1  = 32'd10000;
  localparam sum_t VIB_T2  = 32'd40000;
  localparam sum_t VIB_T3  = 32'd250000;
  localparam sum_t VIB_T4  = 32'd1000000;

  localparam logic [13:0] HUM_T1 = 14'd7000;
  localparam logic [13:0] HUM_T2 = 14'd8000;
  localparam logic [13:0] HUM_T3 = 14'd9000;
  localparam logic [14:0] HUM_RISE    = 15'd1000;
  localparam logic [15:0] LIGHT_DELTA = 16'd1000;

  localparam logic [6:0] SCORE_0   = 7'd0;
  localparam logic [6:0] SCORE_20  = 7'd20;
  localparam logic [6:0] SCORE_30  = 7'd30;
  localparam logic [6:0] SCORE_40  = 7'd40;
  localparam logic [6:0] SCORE_60  = 7'd60;
  localparam logic [6:0] SCORE_70  = 7'd70;
  localparam logic [6:0] SCORE_80  = 7'd80;
  localparam logic [6:0] SCORE_100 = 7'd100;
  localparam logic [5:0] LIGHT_SCORE = 6'd50;

  localparam logic [13:0] W_TILT  = 14'd40;
  localparam logic [13:0] W_VIB   = 14'd30;
  localparam logic [13:0] W_HUM   = 14'd20;
  localparam logic [13:0] W_LIGHT = 14'd10;

  localparam logic [13:0] TOTAL_T1 = 14'd2000;
  localparam logic [13:0] TOTAL_T2 = 14'd4000;
  localparam logic [13:0] TOTAL_T3 = 14'd6000;
  localparam logic [13:0] TOTAL_T4 = 14'd8000;

  localparam logic [2:0] LVL_SAFE     = 3'd0;
  localparam logic [2:0] LVL_LOW      = 3'd1;
  localparam logic [2:0] LVL_MEDIUM   = 3'd2;
  localparam logic [2:0] LVL_HIGH     = 3'd3;
  localparam logic [2:0] LVL_CRITICAL = 3'd4;

  localparam logic [15:0] TILT_MAG_MAX = 16'd32767;
  localparam logic [15:0] ALERT_MAX    = 16'hFFFF;

  function automatic opnd_t abs_opnd(input opnd_t v);
    opnd_t r;
    r = v[OPND_W-1] ? OPND_W'(~v + 1'b1) : v;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/tvrg_if.sv
`default_nettype none

interface tvrg_sample_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] accel_x;
  logic signed [14:0] accel_y;
  logic signed [14:0] accel_z;
  logic signed [15:0] gyro_x;
  logic signed [15:0] gyro_y;
  logic signed [15:0] gyro_z;
  logic signed [15:0] tilt_x;
  logic signed [15:0] tilt_y;
  logic        [13:0] humidity;
  logic        [15:0] light;
  logic               sample_valid;
  logic        [31:0] sample_time;

  modport source (
    output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
           tilt_x, tilt_y, humidity, light, sample_valid, sample_time,
    input  ready
  );
  modport sink (
    input  valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
           tilt_x, tilt_y, humidity, light, sample_valid, sample_time,
    output ready
  );
endinterface

interface tvrg_result_if;
  logic        valid;
  logic        ready;
  logic [14:0] accel_mag;
  logic [14:0] tilt_magnitude;
  logic [15:0] vibration_level;
  logic [6:0]  tilt_score;
  logic [6:0]  vibration_score;
  logic [6:0]  humidity_score;
  logic [5:0]  light_score;
  logic [13:0] total_score;
  logic [2:0]  risk_level;
  logic [31:0] level_duration;
  logic        warning_active;
  logic [15:0] alert_count;

  modport source (
    output valid, accel_mag, tilt_magnitude, vibration_level, tilt_score,
           vibration_score, humidity_score, light_score, total_score, risk_level,
           level_duration, warning_active, alert_count,
    input  ready
  );
  modport sink (
    input  valid, accel_mag, tilt_magnitude, vibration_level, tilt_score,
           vibration_score, humidity_score, light_score, total_score, risk_level,
           level_duration, warning_active, alert_count,
    output ready
  );
endinterface

`default_nettype wire

// File: src/tilt_vibration_risk_grader_top.sv
`default_nettype none

// Grades landslide risk from one sensor sample per word: vector magnitudes, four
// tiered sub-scores, a weighted total, a five-step risk level with its hold time, a
// warning flag with hysteresis and a saturating alert count. A sample is taken
// only when the block is idle; its result is then formed by bit-serial squaring
// (one multiplier bit per cycle for every component of the three vectors in
// parallel), a restoring square root that retires two radicand bits per cycle,
// and scoring. The block then returns to idle, so it takes no new sample before
// it is through with the last. The result sits in an output register, so the next
// sample is taken while an earlier result still waits for its sink; scoring of that
// next sample holds until it is taken.
module tilt_vibration_risk_grader_top (
  input  wire logic     clk,
  input  wire logic     rst,
  tvrg_sample_if.sink   sample_in,
  tvrg_result_if.source result_out
);

  tvrg_pkg::state_t state, state_next;
  logic [tvrg_pkg::STEP_W-1:0] step;

  tvrg_pkg::opnd_t mplier [tvrg_pkg::LANES][tvrg_pkg::COMPS];
  tvrg_pkg::sum_t  mcand  [tvrg_pkg::LANES][tvrg_pkg::COMPS];
  tvrg_pkg::sum_t  acc    [tvrg_pkg::LANES];
  tvrg_pkg::sum_t  rad    [tvrg_pkg::LANES];
  logic [tvrg_pkg::REM_W-1:0] rem [tvrg_pkg::LANES];
  tvrg_pkg::opnd_t root   [tvrg_pkg::LANES];

  logic [13:0] hum_used;
  logic        rise;
  logic        lchg;
  logic [31:0] now;

  logic [13:0] prev_humidity;
  logic [15:0] prev_light;
  logic [2:0]  held_level;
  logic [31:0] level_since;
  logic        warn_flag;
  logic [15:0] alerts_seen;
  logic        out_valid;

  // FSM outputs
  logic take;
  logic squaring;
  logic rooting;
  logic publish;

  always_comb begin
    state_next = state;
    unique case (state)
      tvrg_pkg::ST_IDLE:   if (sample_in.valid) state_next = tvrg_pkg::ST_SQUARE;
      tvrg_pkg::ST_SQUARE: if (step == tvrg_pkg::LAST_STEP) state_next = tvrg_pkg::ST_ROOT;
      tvrg_pkg::ST_ROOT:   if (step == tvrg_pkg::LAST_STEP) state_next = tvrg_pkg::ST_FINISH;
      tvrg_pkg::ST_FINISH: if (!out_valid || result_out.ready) state_next = tvrg_pkg::ST_IDLE;
      default:             state_next = tvrg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    sample_in.ready = 1'b0;
    squaring        = 1'b0;
    rooting         = 1'b0;
    publish         = 1'b0;
    unique case (state)
      tvrg_pkg::ST_IDLE:   sample_in.ready = 1'b1;
      tvrg_pkg::ST_SQUARE: squaring = 1'b1;
      tvrg_pkg::ST_ROOT:   rooting = 1'b1;
      tvrg_pkg::ST_FINISH: publish = !out_valid || result_out.ready;
      default: ;
    endcase
  end

  assign take = sample_in.valid && sample_in.ready;

  // operands at load: magnitudes of each component, zero for a failed read
  tvrg_pkg::opnd_t ld_opnd [tvrg_pkg::LANES][tvrg_pkg::COMPS];
  always_comb begin
    ld_opnd[tvrg_pkg::LANE_ACCEL][0] =
      tvrg_pkg::abs_opnd({sample_in.accel_x[14], sample_in.accel_x});
    ld_opnd[tvrg_pkg::LANE_ACCEL][1] =
      tvrg_pkg::abs_opnd({sample_in.accel_y[14], sample_in.accel_y});
    ld_opnd[tvrg_pkg::LANE_ACCEL][2] =
      tvrg_pkg::abs_opnd({sample_in.accel_z[14], sample_in.accel_z});
    ld_opnd[tvrg_pkg::LANE_GYRO][0]  = tvrg_pkg::abs_opnd(sample_in.gyro_x);
    ld_opnd[tvrg_pkg::LANE_GYRO][1]  = tvrg_pkg::abs_opnd(sample_in.gyro_y);
    ld_opnd[tvrg_pkg::LANE_GYRO][2]  = tvrg_pkg::abs_opnd(sample_in.gyro_z);
    ld_opnd[tvrg_pkg::LANE_TILT][0]  = tvrg_pkg::abs_opnd(sample_in.tilt_x);
    ld_opnd[tvrg_pkg::LANE_TILT][1]  = tvrg_pkg::abs_opnd(sample_in.tilt_y);
    ld_opnd[tvrg_pkg::LANE_TILT][2]  = '0;
    if (!sample_in.sample_valid) begin
      for (int l = 0; l < tvrg_pkg::LANES; l++) begin
        for (int c = 0; c < tvrg_pkg::COMPS; c++) begin
          ld_opnd[l][c] = '0;
        end
      end
    end
  end

  logic [15:0] light_diff;
  logic        ld_rise;
  logic        ld_lchg;
  always_comb begin
    light_diff = (sample_in.light > prev_light) ? sample_in.light - prev_light
                                                : prev_light - sample_in.light;
    ld_rise = sample_in.sample_valid &&
              ({1'b0, sample_in.humidity} > ({1'b0, prev_humidity} + tvrg_pkg::HUM_RISE));
    ld_lchg = sample_in.sample_valid && (light_diff > tvrg_pkg::LIGHT_DELTA);
  end

  // one partial product per component per cycle
  tvrg_pkg::sum_t sq_sum [tvrg_pkg::LANES];
  always_comb begin
    for (int l = 0; l < tvrg_pkg::LANES; l++) begin
      sq_sum[l] = acc[l];
      for (int c = 0; c < tvrg_pkg::COMPS; c++) begin
        if (mplier[l][c][0]) sq_sum[l] = sq_sum[l] + mcand[l][c];
      end
    end
  end

  // two radicand bits per cycle
  logic [tvrg_pkg::REM_W+1:0] rem_sh  [tvrg_pkg::LANES];
  logic [tvrg_pkg::REM_W+1:0] trial   [tvrg_pkg::LANES];
  logic [tvrg_pkg::REM_W-1:0] rem_next  [tvrg_pkg::LANES];
  tvrg_pkg::opnd_t            root_next [tvrg_pkg::LANES];
  always_comb begin
    for (int l = 0; l < tvrg_pkg::LANES; l++) begin
      rem_sh[l] = {rem[l], rad[l][tvrg_pkg::SUM_W-1 -: 2]};
      trial[l]  = {2'b00, root[l], 2'b01};
      if (rem_sh[l] >= trial[l]) begin
        rem_next[l]  = tvrg_pkg::REM_W'(rem_sh[l] - trial[l]);
        root_next[l] = {root[l][tvrg_pkg::OPND_W-2:0], 1'b1};
      end else begin
        rem_next[l]  = rem_sh[l][tvrg_pkg::REM_W-1:0];
        root_next[l] = {root[l][tvrg_pkg::OPND_W-2:0], 1'b0};
      end
    end
  end

  // scoring on exact squared sums
  logic [6:0]  ts, vs, hs_tier, hs;
  logic [7:0]  hs_raw;
  logic [5:0]  ls;
  logic [13:0] total;
  logic [2:0]  lvl;
  logic [31:0] since_new;
  logic        warn_new;
  logic [15:0] alerts_new;
  tvrg_pkg::sum_t tsum, gsum;
  always_comb begin
    tsum = acc[tvrg_pkg::LANE_TILT];
    gsum = acc[tvrg_pkg::LANE_GYRO];

    if (tsum > tvrg_pkg::TILT_T4)      ts = tvrg_pkg::SCORE_100;
    else if (tsum > tvrg_pkg::TILT_T3) ts = tvrg_pkg::SCORE_80;
    else if (tsum > tvrg_pkg::TILT_T2) ts = tvrg_pkg::SCORE_60;
    else if (tsum > tvrg_pkg::TILT_T1) ts = tvrg_pkg::SCORE_30;
    else                               ts = tvrg_pkg::SCORE_0;

    if (gsum > tvrg_pkg::VIB_T4)       vs = tvrg_pkg::SCORE_100;
    else if (gsum > tvrg_pkg::VIB_T3)  vs = tvrg_pkg::SCORE_70;
    else if (gsum > tvrg_pkg::VIB_T2)  vs = tvrg_pkg::SCORE_40;
    else if (gsum > tvrg_pkg::VIB_T1)  vs = tvrg_pkg::SCORE_20;
    else                               vs = tvrg_pkg::SCORE_0;

    if (hum_used > tvrg_pkg::HUM_T3)      hs_tier = tvrg_pkg::SCORE_80;
    else if (hum_used > tvrg_pkg::HUM_T2) hs_tier = tvrg_pkg::SCORE_60;
    else if (hum_used > tvrg_pkg::HUM_T1) hs_tier = tvrg_pkg::SCORE_30;
    else                                  hs_tier = tvrg_pkg::SCORE_0;
    hs_raw = {1'b0, hs_tier} + (rise ? {1'b0, tvrg_pkg::SCORE_30} : 8'd0);
    hs = (hs_raw > {1'b0, tvrg_pkg::SCORE_100}) ? tvrg_pkg::SCORE_100 : hs_raw[6:0];

    ls = lchg ? tvrg_pkg::LIGHT_SCORE : 6'd0;

    total = 14'(14'(ts) * tvrg_pkg::W_TILT) + 14'(14'(vs) * tvrg_pkg::W_VIB)
          + 14'(14'(hs) * tvrg_pkg::W_HUM) + 14'(14'(ls) * tvrg_pkg::W_LIGHT);

    if (total >= tvrg_pkg::TOTAL_T4)      lvl = tvrg_pkg::LVL_CRITICAL;
    else if (total >= tvrg_pkg::TOTAL_T3) lvl = tvrg_pkg::LVL_HIGH;
    else if (total >= tvrg_pkg::TOTAL_T2) lvl = tvrg_pkg::LVL_MEDIUM;
    else if (total >= tvrg_pkg::TOTAL_T1) lvl = tvrg_pkg::LVL_LOW;
    else                                  lvl = tvrg_pkg::LVL_SAFE;

    since_new = (lvl != held_level) ? now : level_since;

    warn_new   = warn_flag;
    alerts_new = alerts_seen;
    if (lvl >= tvrg_pkg::LVL_HIGH) begin
      warn_new = 1'b1;
      if (alerts_seen != tvrg_pkg::ALERT_MAX) alerts_new = alerts_seen + 16'd1;
    end else if (lvl < tvrg_pkg::LVL_MEDIUM) begin
      warn_new = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= tvrg_pkg::ST_IDLE;
      step          <= '0;
      out_valid     <= 1'b0;
      prev_humidity <= '0;
      prev_light    <= '0;
      held_level    <= tvrg_pkg::LVL_SAFE;
      level_since   <= '0;
      warn_flag     <= 1'b0;
      alerts_seen   <= '0;
    end else begin
      state <= state_next;
      if (take || publish) step <= '0;
      else if (squaring || rooting) step <= step + 1'b1;

      if (publish) out_valid <= 1'b1;
      else if (result_out.ready) out_valid <= 1'b0;

      if (take && sample_in.sample_valid) begin
        prev_humidity <= sample_in.humidity;
        prev_light    <= sample_in.light;
      end

      if (publish) begin
        held_level  <= lvl;
        level_since <= since_new;
        warn_flag   <= warn_new;
        alerts_seen <= alerts_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int l = 0; l < tvrg_pkg::LANES; l++) begin
        acc[l] <= '0;
        for (int c = 0; c < tvrg_pkg::COMPS; c++) begin
          mplier[l][c] <= ld_opnd[l][c];
          mcand[l][c]  <= tvrg_pkg::SUM_W'(ld_opnd[l][c]);
        end
      end
      hum_used <= sample_in.sample_valid ? sample_in.humidity : prev_humidity;
      rise     <= ld_rise;
      lchg     <= ld_lchg;
      now      <= sample_in.sample_time;
    end

    if (squaring) begin
      for (int l = 0; l < tvrg_pkg::LANES; l++) begin
        acc[l] <= sq_sum[l];
        for (int c = 0; c < tvrg_pkg::COMPS; c++) begin
          mplier[l][c] <= mplier[l][c] >> 1;
          mcand[l][c]  <= mcand[l][c] << 1;
        end
        // hand the finished sum to the root unit
        if (step == tvrg_pkg::LAST_STEP) begin
          rad[l]  <= sq_sum[l];
          rem[l]  <= '0;
          root[l] <= '0;
        end
      end
    end

    if (rooting) begin
      for (int l = 0; l < tvrg_pkg::LANES; l++) begin
        rad[l]  <= rad[l] << 2;
        rem[l]  <= rem_next[l];
        root[l] <= root_next[l];
      end
    end

    if (publish) begin
      result_out.accel_mag       <= root[tvrg_pkg::LANE_ACCEL][14:0];
      result_out.tilt_magnitude  <= (root[tvrg_pkg::LANE_TILT] > tvrg_pkg::TILT_MAG_MAX)
                                    ? tvrg_pkg::TILT_MAG_MAX[14:0]
                                    : root[tvrg_pkg::LANE_TILT][14:0];
      result_out.vibration_level <= root[tvrg_pkg::LANE_GYRO];
      result_out.tilt_score      <= ts;
      result_out.vibration_score <= vs;
      result_out.humidity_score  <= hs;
      result_out.light_score     <= ls;
      result_out.total_score     <= total;
      result_out.risk_level      <= lvl;
      result_out.level_duration  <= now - since_new;
      result_out.warning_active  <= warn_new;
      result_out.alert_count     <= alerts_new;
    end
  end

  assign result_out.valid = out_valid;

endmodule

`default_nettype wire
